/* design/lsb_first_bit_field_reader_core_assert.svh */
// Assertion macros for the LSB-first bit field reader core.
`ifndef LSB_FIRST_BIT_FIELD_READER_CORE_ASSERT_SVH
`define LSB_FIRST_BIT_FIELD_READER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define LFBR_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition that, once true, implies another in the same cycle
`define LFBR_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

/* design/lfbr_pkg.sv */
// Shared types and constants for the LSB-first bit field reader.
package lfbr_pkg;

  // Byte queue and field limits
  localparam int QUEUE_DEPTH    = 8;
  localparam int MAX_FIELD_BITS = 32;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_NEED       = (MAX_FIELD_BITS + 7) / 8;
  localparam int NEED_W         = $clog2(MAX_NEED + 1);
  localparam int ACC_W          = 8 * MAX_NEED + 8;
  localparam int CMP_W          = 8;

  // Item field widths
  localparam int FW_W    = 6;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam logic [POS_W-1:0] POS_EMPTY = 4'd8;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_PTR_W   = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_ALIGN = 2'd2,
    OP_ABYTE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNDERRUN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Decoded item as handed from front to back
  typedef struct packed {
    op_t             op;
    logic [7:0]      byte_v;
    logic [FW_W-1:0] width;
  } cmd_t;

  // Back-end state snapshot for checking
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [QCNT_W-1:0] cnt;
  } back_stat_t;

endpackage

/* design/lfbr_front.sv */
// Front end: accepts input items, decodes the op and clamps the field width.
module lfbr_front import lfbr_pkg::*; (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] byte_in, [13:8] field_width, [15:14] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        cmd_valid,
  output cmd_t        cmd_data,
  input  logic        cmd_ready
);

  logic [FW_W-1:0] width_raw;

  // Clamp wide reads to the supported field size
  assign width_raw = in_tdata[13:8];

  always_comb begin
    cmd_data.op     = op_t'(in_tuser);
    cmd_data.byte_v = in_tdata[7:0];
    if (width_raw > FW_W'(MAX_FIELD_BITS)) begin
      cmd_data.width = FW_W'(MAX_FIELD_BITS);
    end else begin
      cmd_data.width = width_raw;
    end
  end

  assign cmd_valid = in_tvalid;
  assign in_tready = cmd_ready;

endmodule

/* design/lfbr_cmdq.sv */
// Short command queue that decouples the front end from the back end.
module lfbr_cmdq import lfbr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t                mem_r [CMDQ_DEPTH];
  logic [CQ_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [CQ_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign push_ready = (cnt_r != CQ_CNT_W'(CMDQ_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CQ_CNT_W'(do_push) - CQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

/* design/lfbr_back.sv */
// Back end: byte queue, bit position state, field merge and result register.
module lfbr_back import lfbr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd_data,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [VALUE_W-1:0] out_tdata,
  output logic [1:0]         out_tuser,
  output back_stat_t         stat
);

  // Architectural state
  logic [7:0]         cur_r, cur_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]         q_r [QUEUE_DEPTH];
  logic [7:0]         q_nxt [QUEUE_DEPTH];

  // Result register
  logic               ovalid_r, ovalid_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  status_t            status_r, status_nxt;

  logic                      fire;
  logic [POS_W-1:0]          avail;
  logic [6:0]                need_sum;
  logic [NEED_W-1:0]         need;
  logic [7:0]                tail;
  logic [8*MAX_NEED-1:0]     window;
  logic [ACC_W-1:0]          acc;
  logic [MAX_FIELD_BITS:0]   mask_ext;
  logic [MAX_FIELD_BITS-1:0] field;
  logic [6:0]                pos_calc;
  logic [7:0]                cur_pop;
  logic [NEED_W-1:0]         pop_n;
  logic                      push_en;

  // Output slot is free when empty or being drained
  assign cmd_ready = !ovalid_r || out_tready;
  assign fire      = cmd_valid && cmd_ready;

  // Field merge: leftover bits of the current byte, then whole queued bytes
  always_comb begin
    avail    = pos_r[3] ? '0 : (POS_EMPTY - pos_r);
    need_sum = {1'b0, cmd_data.width} - 7'(avail) + 7'd7;
    need     = need_sum[3 +: NEED_W];
    tail     = cur_r >> pos_r;
    for (int i = 0; i < MAX_NEED; i++) begin
      window[8*i +: 8] = q_r[i];
    end
    acc      = ACC_W'(tail) | (ACC_W'(window) << avail);
    mask_ext = ((MAX_FIELD_BITS + 1)'(1) << cmd_data.width) - 1'b1;
    field    = acc[MAX_FIELD_BITS-1:0] & mask_ext[MAX_FIELD_BITS-1:0];
    pos_calc = {1'b0, cmd_data.width} - 7'(avail) - 7'({need - 1'b1, 3'b000});
    cur_pop  = q_r[0];
    for (int k = 1; k <= MAX_NEED; k++) begin
      if (need == NEED_W'(k)) begin
        cur_pop = q_r[k-1];
      end
    end
  end

  // Execute one command
  always_comb begin
    cur_nxt    = cur_r;
    pos_nxt    = pos_r;
    pop_n      = '0;
    push_en    = 1'b0;
    value_nxt  = '0;
    status_nxt = ST_OK;
    case (cmd_data.op)
      OP_PUSH: begin
        if (cnt_r < QCNT_W'(QUEUE_DEPTH)) begin
          push_en = 1'b1;
        end else begin
          status_nxt = ST_OVERFLOW;
        end
      end
      OP_READ: begin
        if (cmd_data.width == '0) begin
          value_nxt = '0;
        end else if (cmd_data.width <= FW_W'(avail)) begin
          value_nxt = VALUE_W'(field);
          pos_nxt   = pos_r + POS_W'(cmd_data.width);
        end else if (CMP_W'(need) > CMP_W'(cnt_r)) begin
          status_nxt = ST_UNDERRUN;
        end else begin
          value_nxt = VALUE_W'(field);
          pop_n     = need;
          cur_nxt   = cur_pop;
          pos_nxt   = pos_calc[POS_W-1:0];
        end
      end
      OP_ALIGN: begin
        if (pos_r != '0 && !pos_r[3]) begin
          pos_nxt = POS_EMPTY;
        end
      end
      OP_ABYTE: begin
        if (!pos_r[3]) begin
          value_nxt = VALUE_W'(cur_r);
          pos_nxt   = POS_EMPTY;
        end else if (cnt_r == '0) begin
          status_nxt = ST_UNDERRUN;
        end else begin
          value_nxt = VALUE_W'(q_r[0]);
          cur_nxt   = q_r[0];
          pop_n     = NEED_W'(1);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    if (!fire) begin
      push_en = 1'b0;
      pop_n   = '0;
      cur_nxt = cur_r;
      pos_nxt = pos_r;
    end
  end

  // Byte queue as a shift line: pops shift toward the head, pushes land at the tail
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
      for (int k = 1; k <= MAX_NEED; k++) begin
        if (i + k < QUEUE_DEPTH && pop_n == NEED_W'(k)) begin
          q_nxt[i] = q_r[i+k];
        end
      end
      if (push_en && cnt_r == QCNT_W'(i)) begin
        q_nxt[i] = cmd_data.byte_v;
      end
    end
    cnt_nxt = cnt_r + QCNT_W'(push_en) - QCNT_W'(pop_n);
  end

  // Output register handshake
  always_comb begin
    if (fire) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      pos_r    <= POS_EMPTY;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      cur_r    <= cur_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (fire) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = value_r;
  assign out_tuser  = status_r;
  assign stat.pos   = pos_r;
  assign stat.cnt   = cnt_r;

endmodule

/* design/lsb_first_bit_field_reader_core.sv */
// LSB-first bit field reader: bytes are pushed into an 8-entry queue and
// fields of 0 to 32 bits are read back least significant bit first; align
// and aligned-byte reads work on byte boundaries. Every input item yields
// exactly one result item with a 32-bit value and a status code (ok,
// underrun with nothing consumed, overflow with the byte dropped). The block
// takes one item per clock cycle while the result side does not stall: the
// field merge and the queue shift are combinational in the back end. A result
// item is registered: its input item is written into the command queue, then
// executed into the result register, and is held up while the result side
// stalls; the two-entry command queue lets the input side keep accepting
// while a result waits to be taken.
module lsb_first_bit_field_reader_core import lfbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] byte_in, [13:8] field_width, [15:14] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [1:0]  out_tuser   // [1:0] status
);

`include "lsb_first_bit_field_reader_core_assert.svh"

  logic       f_valid, f_ready;
  cmd_t       f_cmd;
  logic       b_valid, b_ready;
  cmd_t       b_cmd;
  back_stat_t b_stat;

  // Decode
  lfbr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (f_valid),
    .cmd_data  (f_cmd),
    .cmd_ready (f_ready)
  );

  // Decoupling queue
  lfbr_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_cmd)
  );

  // Execute
  lfbr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (b_valid),
    .cmd_ready  (b_ready),
    .cmd_data   (b_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .stat       (b_stat)
  );

  // Checks
  `LFBR_ASSERT_ALWAYS(a_cnt_bound, b_stat.cnt <= QCNT_W'(QUEUE_DEPTH), "queue count past depth")
  `LFBR_ASSERT_ALWAYS(a_pos_range, b_stat.pos != '0 && b_stat.pos <= POS_EMPTY, "bad bit position")
  `LFBR_ASSERT_IMPLY(a_err_zero, out_tvalid && out_tuser != ST_OK, out_tdata == '0, "error value")

endmodule

/* bench/lfbr_field_checker.sv */
// Checker for the LSB-first bit field reader: predicts each result item and compares it.
module lfbr_field_checker import lfbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] byte_in, [13:8] field_width, [15:14] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] value
  input  logic [1:0]  out_tuser,  // [1:0] status
  output int          err_count,
  output int          pending_count,
  output int          result_count,
  output int          underrun_count,
  output int          overflow_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } field_result_t;

  // Shadow copy of the reader state
  logic [7:0]       cur_byte;
  logic [POS_W-1:0] bit_pos;
  logic [7:0]       byte_fifo[$];

  // Results still owed by the block, oldest first
  field_result_t expected_results[$];

  // Apply one item to the shadow state and return the result it should give
  function automatic field_result_t predict_field_result(op_t op, logic [7:0] byte_v,
                                                         logic [FW_W-1:0] width);
    field_result_t r;
    int            w;
    int            avail;
    int            need;
    int            shift;
    logic [63:0]   acc;
    logic [63:0]   mask;
    logic [7:0]    b;
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (byte_fifo.size() < QUEUE_DEPTH) byte_fifo.push_back(byte_v);
        else r.status = ST_OVERFLOW;
      end
      OP_READ: begin
        w = (width > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(width);
        if (w != 0) begin
          mask  = (64'd1 << w) - 64'd1;
          avail = (bit_pos >= 8) ? 0 : 8 - int'(bit_pos);
          if (w <= avail) begin
            // field fits in what is left of the current byte
            r.value = VALUE_W'((64'(cur_byte) >> bit_pos) & mask);
            bit_pos = bit_pos + POS_W'(w);
          end else begin
            need = (w - avail + 7) / 8;
            if (need > byte_fifo.size()) begin
              r.status = ST_UNDERRUN;
            end else begin
              acc   = (avail != 0) ? (64'(cur_byte) >> bit_pos) : 64'd0;
              shift = avail;
              for (int i = 0; i < need; i++) begin
                b        = byte_fifo.pop_front();
                acc      = acc | (64'(b) << shift);
                shift    = shift + 8;
                cur_byte = b;
              end
              bit_pos = POS_W'(w - avail - 8 * (need - 1));
              r.value = VALUE_W'(acc & mask);
            end
          end
        end
      end
      OP_ALIGN: begin
        if (bit_pos != 0 && bit_pos < 8) bit_pos = POS_EMPTY;
      end
      default: begin
        // aligned byte: whole current byte if partly used, else the next one
        if (bit_pos < 8) begin
          r.value = VALUE_W'(cur_byte);
          bit_pos = POS_EMPTY;
        end else if (byte_fifo.size() == 0) begin
          r.status = ST_UNDERRUN;
        end else begin
          cur_byte = byte_fifo.pop_front();
          r.value  = VALUE_W'(cur_byte);
          bit_pos  = POS_EMPTY;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    field_result_t exp_r;
    if (!rst_n) begin
      cur_byte = 8'd0;
      bit_pos  = POS_EMPTY;
      byte_fifo.delete();
      expected_results.delete();
      err_count      <= 0;
      result_count   <= 0;
      underrun_count <= 0;
      overflow_count <= 0;
      pending_count  <= 0;
    end else begin
      // result side first: a result never belongs to an item taken on the same edge
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (out_tuser == ST_UNDERRUN) underrun_count <= underrun_count + 1;
        if (out_tuser == ST_OVERFLOW) overflow_count <= overflow_count + 1;
        if (expected_results.size() == 0) begin
          if (err_count < 10)
            $display("[%0t] unexpected result: value=%h status=%0d", $realtime,
                     out_tdata, out_tuser);
          err_count <= err_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tdata !== exp_r.value || out_tuser !== exp_r.status) begin
            if (err_count < 10)
              $display("[%0t] mismatch: value exp=%h got=%h, status exp=%0d got=%0d",
                       $realtime, exp_r.value, out_tdata, exp_r.status, out_tuser);
            err_count <= err_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_field_result(op_t'(in_tuser), in_tdata[7:0],
                                                        in_tdata[13:8]));
      pending_count <= expected_results.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// Top of the bench: clock, reset, item stimulus, result-side stalls and the verdict.
module tb_top import lfbr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 950;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 3000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  int err_count;
  int pending_count;
  int result_count;
  int underrun_count;
  int overflow_count;

  int  op_count[4];
  int  items_sent;
  bit  sender_calm;
  logic hold_req = 1'b0;

  lsb_first_bit_field_reader_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  lfbr_field_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .err_count      (err_count),
    .pending_count  (pending_count),
    .result_count   (result_count),
    .underrun_count (underrun_count),
    .overflow_count (overflow_count)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Field widths: mostly legal, some zero, some above the clamp
  function automatic logic [FW_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 15) return FW_W'($urandom_range(MAX_FIELD_BITS + 1, 63));
    if (r < 30) return FW_W'($urandom_range(25, MAX_FIELD_BITS));
    return FW_W'($urandom_range(1, 24));
  endfunction

  // Offer one item and wait until it is taken
  task automatic offer_item(op_t op, logic [7:0] byte_v, logic [FW_W-1:0] width);
    int g;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, width, byte_v};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    op_count[int'(op)]++;
    items_sent++;
    if (!sender_calm) begin
      g = pick_gap();
      if (g != 0) begin
        in_tvalid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  // Stop sending until every owed result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic push_run(int n);
    repeat (n) offer_item(OP_PUSH, 8'($urandom), FW_W'($urandom));
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int g;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req   <= 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        g = pick_gap();
        if (g != 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
        else repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  initial begin
    int idle;
    idle = 0;
    wait (rst_n);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int kind;
    int r;
    op_t op;
    items_sent = 0;
    foreach (op_count[i]) op_count[i] = 0;
    sender_calm = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-queue cases first
    offer_item(OP_READ,  8'h00, 6'd8);    // read underrun on empty queue
    offer_item(OP_ABYTE, 8'hFF, 6'd63);   // aligned read with nothing queued
    offer_item(OP_ALIGN, 8'h00, 6'd0);    // align already on a boundary
    offer_item(OP_READ,  8'hFF, 6'd0);    // zero-width read
    // fill the queue, then one more to overflow
    offer_item(OP_PUSH, 8'h00, 6'd0);
    offer_item(OP_PUSH, 8'hFF, 6'd63);
    offer_item(OP_PUSH, 8'hA5, 6'd0);
    offer_item(OP_PUSH, 8'h5A, 6'd0);
    offer_item(OP_PUSH, 8'h01, 6'd0);
    offer_item(OP_PUSH, 8'h80, 6'd0);
    offer_item(OP_PUSH, 8'h3C, 6'd0);
    offer_item(OP_PUSH, 8'hC3, 6'd0);
    offer_item(OP_PUSH, 8'h77, 6'd0);     // full queue, byte dropped
    // partial reads, mid-byte align, wide clamp, aligned reads
    offer_item(OP_READ,  8'h00, 6'd3);
    offer_item(OP_ALIGN, 8'h00, 6'd0);    // skips rest of the byte
    offer_item(OP_READ,  8'h00, 6'd63);   // clamps to the max field
    offer_item(OP_READ,  8'h00, 6'd4);
    offer_item(OP_ABYTE, 8'h00, 6'd0);    // mid-byte: whole current byte
    offer_item(OP_ABYTE, 8'h00, 6'd0);    // used-up: pops next byte
    offer_item(OP_READ,  8'h00, 6'd32);   // not enough queued
    offer_item(OP_READ,  8'h00, 6'd40);
    drain_results();

    // Long result-side hold-off while items keep coming
    hold_req    <= 1'b1;
    sender_calm = 1'b1;
    @(posedge clk);
    wait (!hold_req);                     // hold-off has started
    push_run(6);
    repeat (14) offer_item(OP_READ, 8'($urandom), pick_width());
    drain_results();

    // Random part: mostly push-then-read bursts with random content
    while (items_sent < RANDOM_ITEMS) begin
      kind        = $urandom_range(0, 99);
      sender_calm = ($urandom_range(0, 9) < 3);
      if (kind < 62) begin
        push_run($urandom_range(1, QUEUE_DEPTH));
        repeat ($urandom_range(1, 6)) begin
          r  = $urandom_range(0, 99);
          op = (r < 70) ? OP_READ : (r < 85) ? OP_ABYTE : OP_ALIGN;
          offer_item(op, 8'($urandom), pick_width());
        end
      end else if (kind < 70) begin
        push_run(QUEUE_DEPTH + 2);
      end else if (kind < 74) begin
        drain_results();
      end else begin
        offer_item(op_t'($urandom_range(0, 3)), 8'($urandom), FW_W'($urandom));
      end
    end

    // Wait for the last results, then wait out any stray outputs
    drain_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d items: %0d pushes, %0d field reads, %0d aligns, %0d byte reads",
             items_sent, op_count[OP_PUSH], op_count[OP_READ], op_count[OP_ALIGN],
             op_count[OP_ABYTE]);
    $display("Got %0d results, %0d underruns, %0d overflows, %0d mismatches",
             result_count, underrun_count, overflow_count, err_count);
    if (err_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
